// ===== design/ssif_pkg.sv =====
// Package with format codes and shared types for the sample converter.
`timescale 1ns / 1ps
package ssif_pkg;
    localparam logic [7:0] FMT_IBM   = 8'd1;
    localparam logic [7:0] FMT_INT32 = 8'd2;
    localparam logic [7:0] FMT_INT16 = 8'd3;
    localparam logic [7:0] FMT_IEEE  = 8'd5;

    typedef enum logic [1:0] {
        OP_PASS = 2'd0,
        OP_PACK = 2'd1
    } op_t;

    // Register byte addresses.
    localparam logic [2:0] ADDR_FORMAT = 3'd0;
    localparam logic [2:0] ADDR_BE     = 3'd4;
endpackage

// ===== design/seismic_sample_to_ieee_float_unit.sv =====
// Top level of the seismic sample to IEEE single converter.
`timescale 1ns / 1ps
// Usage: samples enter on sample_word with in_valid/in_stall; converted
// items leave on ieee_bits with out_valid/out_stall. An item is accepted
// on a rising edge with valid high and stall low.
// The format code and byte-order flag are written over the APB port (format_code at 0,
// big_endian at 4); the user must do so only while the block is idle (not enforced).
// Pipeline: stage 1 selects the rule, byte order and magnitude; stage 2
// finds the leading one and the scale; stage 3 shifts, rounds and packs.
// An accepted item passes the stage 1, 2 and 3 registers to out_valid;
// throughput is one item per cycle while out_stall is low.
// When out_stall is high a stage holds only if it and every later stage are full;
// in_stall rises only if all three stages hold an item; bubbles are squeezed out.
// Reset clears the valid bits and sets format_code to 1 and big_endian
// to 1 (IBM float decoding).
module seismic_sample_to_ieee_float_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] ieee_bits
);
    import ssif_pkg::*;

    logic [7:0]  format_reg;
    logic        be_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_IBM;
            be_reg     <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_FORMAT)
            begin
                format_reg <= pwdata[7:0];
            end
            else if (paddr == ADDR_BE)
            begin
                be_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_FORMAT)
        begin
            prdata = {24'd0, format_reg};
        end
        else if (paddr == ADDR_BE)
        begin
            prdata = {31'd0, be_reg};
        end
    end

    // Pipeline advance: each stage moves when the one after it can take.
    logic v1_reg, v2_reg, v3_reg;
    logic adv3, adv2, adv1;
    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    // Stage 1: rule selection and magnitude extraction.
    logic [31:0] rev_w;
    op_t         op1_next;
    logic        sign1_next;
    logic [31:0] mag1_next;
    logic signed [9:0] exp1_next;
    logic [31:0] pass1_next;
    logic [15:0] h16;
    logic [31:0] i32;

    assign rev_w = {sample_word[7:0], sample_word[15:8],
                    sample_word[23:16], sample_word[31:24]};

    always_comb
    begin
        op1_next   = OP_PASS;
        sign1_next = 1'b0;
        mag1_next  = 32'd0;
        exp1_next  = 10'sd0;
        pass1_next = rev_w;
        h16        = be_reg ? sample_word[31:16] : {sample_word[23:16], sample_word[31:24]};
        i32        = be_reg ? sample_word : rev_w;
        case (format_reg)
            FMT_IBM:
            begin
                if (be_reg)
                begin
                    op1_next   = OP_PACK;
                    sign1_next = sample_word[31];
                    mag1_next  = {8'd0, sample_word[23:0]};
                    exp1_next  = 10'(signed'({1'b0, sample_word[30:24], 2'b00}))
                                 - 10'sd280;
                end
            end
            FMT_INT32:
            begin
                op1_next   = OP_PACK;
                sign1_next = i32[31];
                mag1_next  = i32[31] ? (~i32 + 32'd1) : i32;
            end
            FMT_INT16:
            begin
                op1_next   = OP_PACK;
                sign1_next = h16[15];
                mag1_next  = h16[15] ? (32'h10000 - {16'd0, h16}) : {16'd0, h16};
            end
            FMT_IEEE:
            begin
                pass1_next = be_reg ? sample_word : rev_w;
            end
            default:
            begin
                pass1_next = rev_w;
            end
        endcase
    end

    op_t         op1_reg, op2_reg;
    logic        sign1_reg, sign2_reg;
    logic [31:0] mag1_reg, mag2_reg;
    logic signed [9:0] exp1_reg;
    logic [31:0] pass1_reg, pass2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            op1_reg   <= op1_next;
            sign1_reg <= sign1_next;
            mag1_reg  <= mag1_next;
            exp1_reg  <= exp1_next;
            pass1_reg <= pass1_next;
        end
    end

    // Stage 2: leading-one position, biased exponent and shift amount.
    logic [4:0] p2_next;
    logic signed [10:0] e2_next;
    logic signed [10:0] s2_next;
    always_comb
    begin
        p2_next = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag1_reg[i])
            begin
                p2_next = 5'(i);
            end
        end
        e2_next = 11'(signed'({1'b0, p2_next})) + 11'(exp1_reg) + 11'sd127;
        s2_next = (e2_next >= 11'sd1) ? (11'(signed'({1'b0, p2_next})) - 11'sd23)
                                      : (-11'sd149 - 11'(exp1_reg));
    end

    logic signed [10:0] e2_reg, s2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            op2_reg   <= op1_reg;
            sign2_reg <= sign1_reg;
            mag2_reg  <= mag1_reg;
            pass2_reg <= pass1_reg;
            e2_reg    <= e2_next;
            s2_reg    <= s2_next;
        end
    end

    // Stage 3: shift, round to nearest even, pack.
    logic [31:0] r3_next;
    logic [32:0] m3;
    logic [31:0] remv, halfv, maskv;
    logic [5:0]  sh;
    logic signed [10:0] e3;
    always_comb
    begin
        m3    = 33'd0;
        remv  = 32'd0;
        halfv = 32'd0;
        maskv = 32'd0;
        sh    = 6'd0;
        e3    = e2_reg;
        if (s2_reg <= 11'sd0)
        begin
            // Left shift never exceeds 23 for a nonzero magnitude.
            sh = 6'(-s2_reg);
            m3 = 33'({1'b0, mag2_reg} << sh);
        end
        else if (s2_reg >= 11'sd33)
        begin
            m3 = 33'd0;
        end
        else
        begin
            sh    = 6'(s2_reg);
            maskv = (32'd1 << sh) - 32'd1;
            remv  = mag2_reg & maskv;
            halfv = 32'd1 << (sh - 6'd1);
            m3    = {1'b0, mag2_reg >> sh};
            if (remv > halfv || (remv == halfv && m3[0]))
            begin
                m3 = m3 + 33'd1;
            end
        end
        r3_next = {sign2_reg, 31'd0};
        if (op2_reg == OP_PASS)
        begin
            r3_next = pass2_reg;
        end
        else if (mag2_reg != 32'd0)
        begin
            if (e2_reg >= 11'sd1)
            begin
                if (m3[24])
                begin
                    m3 = m3 >> 1;
                    e3 = e2_reg + 11'sd1;
                end
                if (e3 >= 11'sd255)
                begin
                    r3_next = {sign2_reg, 8'hff, 23'd0};
                end
                else
                begin
                    r3_next = {sign2_reg, e3[7:0], m3[22:0]};
                end
            end
            else
            begin
                r3_next = {sign2_reg, m3[30:0]};
            end
        end
    end

    logic [31:0] r3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            r3_reg <= r3_next;
        end
    end

    assign out_valid = v3_reg;
    assign ieee_bits = r3_reg;

    // A stalled result must hold until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ieee_bits))
        else $error("result changed under stall");
    // Input is stalled only when the pipeline is full.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && out_stall)
        else $error("input stalled with room in pipeline");
    // An accepted item reaches the output stage through stages 1 to 3 when out_stall stays low.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("item lost in pipeline");
endmodule
